>>> rtl/pps_pkg.sv
`default_nettype none
package pps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int SLOT_W   = 4;
  localparam int TIME_W   = 32;
  localparam int ARR_W    = 16;
  localparam int BURST_W  = 16;
  localparam int PRIO_W   = 8;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] executed;
    logic [TIME_W-1:0]  first_run;
  } job_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_CALC,
    ST_POST
  } pps_state_e;

  typedef struct packed {
    logic             load_we;
    logic             scan_clr;
    logic             scan_rd;
    logic [IDX_W-1:0] scan_idx;
    logic             fetch;
    logic             calc;
    logic             post;
  } pps_cmd_t;

  typedef struct packed {
    logic out_free;
  } pps_status_t;

  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] t);
    sat_inc = (t == {TIME_W{1'b1}}) ? t : t + TIME_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> rtl/pps_ctrl.sv
`default_nettype none
module pps_ctrl
  import pps_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         mode_i,
  output logic        in_ready_o,
  input  pps_status_t status_i,
  output pps_cmd_t    cmd_o
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_JOBS - 1);

  pps_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    idx_d            = idx_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.scan_idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.scan_clr = 1'b1;
            idx_d          = '0;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_POST;
      end
      ST_POST: begin
        if (status_i.out_free) begin
          cmd_o.post = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pps_datapath.sv
`default_nettype none
module pps_datapath
  import pps_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  pps_cmd_t           cmd_i,
  output pps_status_t        status_o,
  input  wire  [ARR_W-1:0]   arrival_time_i,
  input  wire  [BURST_W-1:0] burst_time_i,
  input  wire  [PRIO_W-1:0]  priority_req_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               idle_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [TIME_W-1:0]  start_time_o,
  output logic               finished_o,
  output logic [TIME_W-1:0]  turnaround_o,
  output logic [TIME_W-1:0]  waiting_o,
  output logic [TIME_W-1:0]  response_o,
  output logic               all_done_o
);

  job_rec_t mem_q [MAX_JOBS];
  job_rec_t rd_q;

  logic [MAX_JOBS-1:0] pending_q;
  logic [CNT_W-1:0]    count_q;
  logic [TIME_W-1:0]   now_q;
  logic                eval_en_q;
  logic [IDX_W-1:0]    eval_idx_q;
  logic                found_q;
  logic [PRIO_W-1:0]   best_prio_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [TIME_W-1:0]   start_q;
  logic                fin_q;
  logic [TIME_W-1:0]   ta_q;
  logic [TIME_W-1:0]   resp_q;
  logic [BURST_W-1:0]  burst_q;
  logic                out_valid_q;

  logic             load_ok;
  logic [IDX_W-1:0] load_idx;
  logic [IDX_W-1:0] rd_addr;
  logic             elig;
  job_rec_t         load_rec;
  job_rec_t         upd_rec;
  logic [BURST_W-1:0] exec_new;
  logic [TIME_W-1:0]  first_new;
  logic [TIME_W-1:0]  done_t;
  logic               fin_new;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  job_rec_t           wr_rec;
  logic [TIME_W-1:0]  wait_t;

  assign load_ok  = cmd_i.load_we && (count_q < CNT_W'(MAX_JOBS));
  assign load_idx = count_q[IDX_W-1:0];
  assign rd_addr  = cmd_i.fetch ? best_idx_q : cmd_i.scan_idx;
  assign elig     = eval_en_q && pending_q[eval_idx_q] &&
                    ({{(TIME_W-ARR_W){1'b0}}, rd_q.arrival} <= now_q) &&
                    (!found_q || (rd_q.prio < best_prio_q));

  always_comb begin
    load_rec           = '0;
    load_rec.arrival   = arrival_time_i;
    load_rec.burst     = (burst_time_i == '0) ? BURST_W'(1) : burst_time_i;
    load_rec.prio      = priority_req_i;
    exec_new           = rd_q.executed + BURST_W'(1);
    first_new          = (rd_q.executed == '0) ? now_q : rd_q.first_run;
    fin_new            = (exec_new >= rd_q.burst);
    done_t             = sat_inc(now_q);
    upd_rec            = rd_q;
    upd_rec.executed   = exec_new;
    upd_rec.first_run  = first_new;
    mem_we             = load_ok || (cmd_i.calc && found_q);
    wr_addr            = load_ok ? load_idx : best_idx_q;
    wr_rec             = load_ok ? load_rec : upd_rec;
    wait_t             = (ta_q >= {{(TIME_W-BURST_W){1'b0}}, burst_q}) ?
                         ta_q - {{(TIME_W-BURST_W){1'b0}}, burst_q} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_rec;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      count_q     <= '0;
      now_q       <= '0;
      eval_en_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      eval_en_q <= cmd_i.scan_rd;
      if (load_ok) begin
        pending_q[load_idx] <= 1'b1;
        count_q             <= count_q + CNT_W'(1);
      end
      if (cmd_i.scan_clr) begin
        found_q <= 1'b0;
      end else if (elig) begin
        found_q <= 1'b1;
      end
      if (cmd_i.calc) begin
        now_q <= sat_inc(now_q);
        if (found_q && fin_new) begin
          pending_q[best_idx_q] <= 1'b0;
        end
      end
      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q <= cmd_i.scan_idx;
    if (elig) begin
      best_prio_q <= rd_q.prio;
      best_idx_q  <= eval_idx_q;
    end
    if (cmd_i.calc) begin
      start_q <= now_q;
      fin_q   <= found_q && fin_new;
      ta_q    <= done_t - {{(TIME_W-ARR_W){1'b0}}, rd_q.arrival};
      resp_q  <= first_new - {{(TIME_W-ARR_W){1'b0}}, rd_q.arrival};
      burst_q <= rd_q.burst;
    end
    if (cmd_i.post) begin
      idle_o       <= !found_q;
      slot_o       <= found_q ? SLOT_W'(best_idx_q) : '0;
      start_time_o <= start_q;
      finished_o   <= fin_q;
      turnaround_o <= fin_q ? ta_q : '0;
      waiting_o    <= fin_q ? wait_t : '0;
      response_o   <= fin_q ? resp_q : '0;
      all_done_o   <= (pending_q == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

>>> rtl/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler over a table of MAX_JOBS jobs.
// Input channel (in_valid_i/in_ready_o): mode_i = 0 loads a job into the
// next slot and gives no result; mode_i = 1 is a tick, one time unit.
// Output channel (out_valid_o/out_ready_i): one result per tick.
// A load is written as it is taken; loads can be sent every cycle while idle.
// A tick scans every slot in turn through the job table's single read port,
// one slot per cycle, then fetches and updates the chosen job and posts the
// result to the output register; only then is the next item taken, so a
// tick is through before the next one starts.
// Inputs are taken only while no tick is in progress.
// A result held in the output register does not block new items; if the
// receiver stalls, a following tick completes its scan and waits before
// presenting its result until the previous one has been taken.
// Reset clears the pending bits, the job count, the clock and the output
// valid; the job table itself is not cleared and needs no clearing pass.
`default_nettype none
module preemptive_priority_scheduler_top
  import pps_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                mode_i,
  input  wire  [ARR_W-1:0]   arrival_time_i,
  input  wire  [BURST_W-1:0] burst_time_i,
  input  wire  [PRIO_W-1:0]  priority_req_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               idle_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [TIME_W-1:0]  start_time_o,
  output logic               finished_o,
  output logic [TIME_W-1:0]  turnaround_o,
  output logic [TIME_W-1:0]  waiting_o,
  output logic [TIME_W-1:0]  response_o,
  output logic               all_done_o
);

  pps_cmd_t    cmd;
  pps_status_t status;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pps_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .arrival_time_i (arrival_time_i),
    .burst_time_i   (burst_time_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .idle_o         (idle_o),
    .slot_o         (slot_o),
    .start_time_o   (start_time_o),
    .finished_o     (finished_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .response_o     (response_o),
    .all_done_o     (all_done_o)
  );

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import pps_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic              idle;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] start;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] response;
    logic              all_done;
  } tick_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               mode_i         = MODE_LOAD;
  logic [ARR_W-1:0]   arrival_time_i = '0;
  logic [BURST_W-1:0] burst_time_i   = '0;
  logic [PRIO_W-1:0]  priority_req_i = '0;
  logic               out_ready_i    = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               idle_o;
  logic [SLOT_W-1:0]  slot_o;
  logic [TIME_W-1:0]  start_time_o;
  logic               finished_o;
  logic [TIME_W-1:0]  turnaround_o;
  logic [TIME_W-1:0]  waiting_o;
  logic [TIME_W-1:0]  response_o;
  logic               all_done_o;

  preemptive_priority_scheduler_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .arrival_time_i (arrival_time_i),
    .burst_time_i   (burst_time_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .idle_o         (idle_o),
    .slot_o         (slot_o),
    .start_time_o   (start_time_o),
    .finished_o     (finished_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .response_o     (response_o),
    .all_done_o     (all_done_o)
  );

  // scheduler mirror
  logic [ARR_W-1:0]   job_arr   [MAX_JOBS];
  logic [BURST_W-1:0] job_len   [MAX_JOBS];
  logic [PRIO_W-1:0]  job_prio  [MAX_JOBS];
  logic [BURST_W-1:0] job_units [MAX_JOBS];
  logic [TIME_W-1:0]  job_first [MAX_JOBS];
  logic               job_pend  [MAX_JOBS];
  int unsigned        job_cnt    = 0;
  logic [TIME_W-1:0]  sched_time = '0;
  tick_result_t       sched_q[$];
  tick_result_t       want;

  int unsigned n_loads = 0, n_dropped = 0, n_ticks = 0, n_idle = 0, n_finished = 0;
  int unsigned n_checked = 0, n_errors = 0, cycle_cnt = 0, rx_hold = 0;
  bit          quiet = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = quiet || ($urandom_range(99) >= 32);
    end
  end

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_val,
                             input logic [TIME_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_q.size() == 0) begin
        $error("result transfer with no tick outstanding");
        n_errors++;
      end else begin
        want = sched_q.pop_front();
        n_checked++;
        check_field("idle", want.idle, idle_o);
        check_field("slot", want.slot, slot_o);
        check_field("start_time", want.start, start_time_o);
        check_field("finished", want.finished, finished_o);
        check_field("turnaround", want.turnaround, turnaround_o);
        check_field("waiting", want.waiting, waiting_o);
        check_field("response", want.response, response_o);
        check_field("all_done", want.all_done, all_done_o);
      end
    end
  end

  task automatic predict_item(input logic mode, input logic [ARR_W-1:0] arr,
                              input logic [BURST_W-1:0] len, input logic [PRIO_W-1:0] prio);
    tick_result_t      r;
    int unsigned       pick;
    logic              found;
    logic [PRIO_W-1:0] best;
    logic [TIME_W-1:0] done_at;
    if (mode == MODE_LOAD) begin
      n_loads++;
      if (job_cnt < MAX_JOBS) begin
        job_arr[job_cnt]   = arr;
        job_len[job_cnt]   = (len == '0) ? BURST_W'(1) : len;
        job_prio[job_cnt]  = prio;
        job_units[job_cnt] = '0;
        job_first[job_cnt] = '0;
        job_pend[job_cnt]  = 1'b1;
        job_cnt++;
      end else begin
        n_dropped++;
      end
      return;
    end
    n_ticks++;
    r = '0;
    found = 1'b0;
    pick = 0;
    best = '0;
    r.start = sched_time;
    for (int i = 0; i < job_cnt; i++) begin
      if (job_pend[i] && TIME_W'(job_arr[i]) <= sched_time && (!found || job_prio[i] < best)) begin
        found = 1'b1;
        best = job_prio[i];
        pick = i;
      end
    end
    if (sched_time != '1) sched_time++;
    if (!found) begin
      r.idle = 1'b1;
      n_idle++;
    end else begin
      r.slot = pick[SLOT_W-1:0];
      if (job_units[pick] == '0) job_first[pick] = r.start;
      job_units[pick]++;
      if (job_units[pick] >= job_len[pick]) begin
        done_at = (r.start == '1) ? r.start : r.start + 1;
        job_pend[pick] = 1'b0;
        r.finished = 1'b1;
        r.turnaround = done_at - TIME_W'(job_arr[pick]);
        r.waiting = (r.turnaround >= TIME_W'(job_len[pick])) ?
                    r.turnaround - TIME_W'(job_len[pick]) : '0;
        r.response = job_first[pick] - TIME_W'(job_arr[pick]);
        n_finished++;
      end
    end
    r.all_done = 1'b1;
    for (int i = 0; i < job_cnt; i++) if (job_pend[i]) r.all_done = 1'b0;
    sched_q.push_back(r);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic mode, input logic [ARR_W-1:0] arr,
                           input logic [BURST_W-1:0] len, input logic [PRIO_W-1:0] prio);
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    mode_i         = mode;
    arrival_time_i = arr;
    burst_time_i   = len;
    priority_req_i = prio;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(mode, arr, len, prio);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic test_empty_table();
    repeat (2) send_tick();
  endtask

  // zero burst, tie on priority, preemption, late load with top priority
  task automatic test_priority_rules();
    send_item(MODE_LOAD, 16'd0, 16'd0, 8'hFF);
    repeat (2) send_tick();
    send_item(MODE_LOAD, 16'd4, 16'd2, 8'd7);
    send_item(MODE_LOAD, 16'd4, 16'd2, 8'd7);
    send_item(MODE_LOAD, 16'd3, 16'd3, 8'd9);
    repeat (6) send_tick();
    send_item(MODE_LOAD, 16'd0, 16'd1, 8'h00);
    repeat (3) send_tick();
  endtask

  task automatic test_random(input int unsigned count, input bit calm);
    logic [ARR_W-1:0] arr;
    quiet = calm;
    for (int unsigned n = 0; n < count; n++) begin
      if (job_cnt < MAX_JOBS - 2 && $urandom_range(79) == 0) begin
        if ($urandom_range(1) == 0) arr = ARR_W'($urandom_range(sched_time));
        else arr = ARR_W'(sched_time + $urandom_range(60));
        send_item(MODE_LOAD, arr, BURST_W'($urandom_range(200)), PRIO_W'($urandom));
      end else begin
        send_tick();
      end
    end
    quiet = 1'b0;
  endtask

  // receiver stalls long enough for a held result plus a finished scan
  task automatic test_backpressure();
    rx_hold = 300;
    repeat (12) send_tick();
  endtask

  task automatic test_drain_pause();
    while (sched_q.size() != 0) @(negedge clk_i);
    repeat (4) send_tick();
  endtask

  // field extremes, then loads into a full table
  task automatic test_table_full();
    send_item(MODE_LOAD, 16'hFFFF, 16'hFFFF, 8'h00);
    send_item(MODE_LOAD, 16'h0000, 16'hFFFF, 8'hFF);
    while (job_cnt < MAX_JOBS)
      send_item(MODE_LOAD, ARR_W'($urandom_range(sched_time)), BURST_W'($urandom_range(9)),
                PRIO_W'($urandom));
    repeat (3) send_item(MODE_LOAD, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    repeat (8) send_tick();
  endtask

  initial begin
    for (int i = 0; i < MAX_JOBS; i++) job_pend[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_priority_rules();
    test_random(600, 1'b0);
    test_random(250, 1'b1);
    test_backpressure();
    test_drain_pause();
    test_random(650, 1'b0);
    test_table_full();
    while (sched_q.size() != 0) @(negedge clk_i);
    repeat (MAX_JOBS + 8) @(negedge clk_i);
    $display("run: %0d loads (%0d dropped on a full table), %0d ticks, %0d idle",
             n_loads, n_dropped, n_ticks, n_idle);
    $display("run: %0d job completions, %0d results checked, %0d cycles",
             n_finished, n_checked, cycle_cnt);
    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
